@@ rtl/timer_bank_oneshot_periodic_macros.svh @@
`ifndef TIMER_BANK_ONESHOT_PERIODIC_MACROS_SVH
`define TIMER_BANK_ONESHOT_PERIODIC_MACROS_SVH

// condition must never hold while out of reset
`define TBOP_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// consequence must hold in the same cycle
`define TBOP_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequence must hold in the next cycle
`define TBOP_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/tbop_pkg.sv @@
`default_nettype none

package tbop_pkg;

  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_TICK   = 2'd2;
  localparam logic [1:0] REQ_NONE   = 2'd3;

  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_FIRE   = 2'd2;
  localparam logic [1:0] KIND_DONE   = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] target;
    logic [31:0] message;
    logic [31:0] delay;
    logic [31:0] interval;
    logic [3:0]  slot;
    logic [31:0] elapsed;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  slot;
    logic [15:0] target;
    logic [31:0] message;
    logic        full;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [15:0] target;
    logic [31:0] message;
    logic [31:0] remaining;
    logic [31:0] interval;
  } slot_t;

endpackage

`default_nettype wire

@@ rtl/tbop_ram.sv @@
`default_nettype none

module tbop_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/tbop_fifo.sv @@
`default_nettype none

module tbop_fifo #(
  parameter type item_t = logic
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire item_t din,
  output logic       full,
  input  wire logic  pop,
  output item_t      dout,
  output logic       empty
);

  item_t      mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

`default_nettype wire

@@ rtl/tbop_front.sv @@
`default_nettype none

module tbop_front
  import tbop_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  req_type,
  input  wire logic [15:0] target_id,
  input  wire logic [31:0] message_token,
  input  wire logic [31:0] delay_time,
  input  wire logic [31:0] reload_interval,
  input  wire logic [3:0]  slot_index,
  input  wire logic [31:0] elapsed_time,
  output logic             cmd_valid,
  input  wire logic        cmd_take,
  output cmd_t             cmd
);

  cmd_t cmd_in;
  logic enq;
  logic q_empty;

  // unknown requests are taken and dropped
  assign enq = push && (req_type != REQ_NONE);

  always_comb begin
    cmd_in.op       = req_type;
    cmd_in.target   = target_id;
    cmd_in.message  = message_token;
    cmd_in.delay    = delay_time;
    cmd_in.interval = reload_interval;
    cmd_in.slot     = slot_index;
    cmd_in.elapsed  = elapsed_time;
  end

  tbop_fifo #(.item_t(cmd_t)) u_cmdq (
    .clk   (clk),
    .rst   (rst),
    .push  (enq),
    .din   (cmd_in),
    .full  (full),
    .pop   (cmd_take),
    .dout  (cmd),
    .empty (q_empty)
  );

  assign cmd_valid = !q_empty;

endmodule

`default_nettype wire

@@ rtl/tbop_back.sv @@
`default_nettype none

module tbop_back
  import tbop_pkg::*;
#(
  parameter int TIMER_SLOTS = 16,
  localparam int SW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_valid,
  output logic      cmd_take,
  input  wire cmd_t cmd,
  input  wire logic res_ok,
  output logic      res_push,
  output result_t   res
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_TREAD = 2'd1;
  localparam logic [1:0] ST_TEVAL = 2'd2;
  localparam logic [1:0] ST_TDONE = 2'd3;

  localparam logic [SW-1:0] LAST_SLOT = SW'(TIMER_SLOTS - 1);

  logic [1:0]             state, state_next;
  logic [SW-1:0]          s, s_next;
  logic [31:0]            dt, dt_next;
  logic [TIMER_SLOTS-1:0] in_use, in_use_next;

  logic                   we;
  logic [SW-1:0]          waddr;
  slot_t                  wdata;
  logic [SW-1:0]          raddr;
  logic [$bits(slot_t)-1:0] rdata;
  slot_t                  rd;

  logic                   free_found;
  logic [SW-1:0]          free_idx;
  logic [SW+3:0]          free_w;
  logic [SW+3:0]          s_w;
  logic [SW+3:0]          rm_w;
  logic [SW-1:0]          rm_addr;
  logic                   rm_ok;
  logic                   active;
  logic                   fire;
  logic                   adv;

  assign rd      = rdata;
  assign free_w  = {4'b0, free_idx};
  assign s_w     = {4'b0, s};
  assign rm_w    = {{SW{1'b0}}, cmd.slot};
  assign rm_addr = rm_w[SW-1:0];
  assign rm_ok   = 7'(cmd.slot) < 7'(TIMER_SLOTS);
  assign active  = in_use[s] && (rd.target != 16'd0);
  assign fire    = active && (rd.remaining <= dt);
  assign adv     = !fire || res_ok;

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
      if (!in_use[i]) begin
        free_found = 1'b1;
        free_idx   = SW'(i);
      end
    end
  end

  always_comb begin
    state_next  = state;
    s_next      = s;
    dt_next     = dt;
    in_use_next = in_use;
    we          = 1'b0;
    waddr       = s;
    wdata       = rd;
    raddr       = s;
    cmd_take    = 1'b0;
    res_push    = 1'b0;
    res         = '0;
    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          case (cmd.op)
            REQ_ADD: begin
              if (res_ok) begin
                cmd_take  = 1'b1;
                res_push  = 1'b1;
                res.kind  = KIND_ADD;
                res.last  = 1'b1;
                if (free_found) begin
                  res.slot            = free_w[3:0];
                  in_use_next[free_idx] = 1'b1;
                  we                  = 1'b1;
                  waddr               = free_idx;
                  wdata.target        = cmd.target;
                  wdata.message       = cmd.message;
                  wdata.remaining     = cmd.delay;
                  wdata.interval      = cmd.interval;
                end else begin
                  res.full = 1'b1;
                end
              end
            end
            REQ_REMOVE: begin
              if (res_ok) begin
                cmd_take = 1'b1;
                res_push = 1'b1;
                res.kind = KIND_REMOVE;
                res.slot = cmd.slot;
                res.last = 1'b1;
                if (rm_ok) begin
                  in_use_next[rm_addr] = 1'b0;
                end
              end
            end
            REQ_TICK: begin
              cmd_take   = 1'b1;
              dt_next    = cmd.elapsed;
              s_next     = '0;
              state_next = ST_TREAD;
            end
            default: begin
              cmd_take = 1'b1;
            end
          endcase
        end
      end
      ST_TREAD: begin
        state_next = ST_TEVAL;
      end
      ST_TEVAL: begin
        if (adv) begin
          if (fire) begin
            res_push    = 1'b1;
            res.kind    = KIND_FIRE;
            res.slot    = s_w[3:0];
            res.target  = rd.target;
            res.message = rd.message;
            if (rd.interval != 32'd0) begin
              we              = 1'b1;
              wdata.remaining = rd.interval;
            end else begin
              in_use_next[s] = 1'b0;
            end
          end else if (active) begin
            we              = 1'b1;
            wdata.remaining = rd.remaining - dt;
          end
          if (s == LAST_SLOT) begin
            state_next = ST_TDONE;
          end else begin
            s_next = s + 1'b1;
            raddr  = s + 1'b1;
          end
        end
      end
      ST_TDONE: begin
        if (res_ok) begin
          res_push   = 1'b1;
          res.kind   = KIND_DONE;
          res.last   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      s      <= '0;
      in_use <= '0;
    end else begin
      state  <= state_next;
      s      <= s_next;
      in_use <= in_use_next;
    end
  end

  always_ff @(posedge clk) begin
    dt <= dt_next;
  end

  tbop_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (TIMER_SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

endmodule

`default_nettype wire

@@ rtl/timer_bank_oneshot_periodic.sv @@
`default_nettype none

`include "timer_bank_oneshot_periodic_macros.svh"

// Bank of TIMER_SLOTS countdown timers behind a two-word request queue and a
// two-word result queue. Add and remove are handled in the engine's idle state
// and give one word each, once the result queue has room. A tick steps through
// taking the request, starting the read, one visit per slot through the slot
// RAM's single read port (fire words go out as they are found), and the closing
// done word, and waits whenever a fire or done word meets a full result queue.
// Occupancy flags reset at once, so no clearing pass follows reset. Request
// type 3 is accepted and dropped without result.
module timer_bank_oneshot_periodic
  import tbop_pkg::*;
#(
  parameter int TIMER_SLOTS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  req_type,
  input  wire logic [15:0] target_id,
  input  wire logic [31:0] message_token,
  input  wire logic [31:0] delay_time,
  input  wire logic [31:0] reload_interval,
  input  wire logic [3:0]  slot_index,
  input  wire logic [31:0] elapsed_time,
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       result_kind,
  output logic [3:0]       result_slot,
  output logic [15:0]      fired_target,
  output logic [31:0]      fired_message,
  output logic             bank_full,
  output logic             last_result
);

  cmd_t    cmd;
  logic    cmd_valid;
  logic    cmd_take;
  result_t res;
  result_t res_out;
  logic    res_push;
  logic    outq_full;

  tbop_front u_front (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .req_type        (req_type),
    .target_id       (target_id),
    .message_token   (message_token),
    .delay_time      (delay_time),
    .reload_interval (reload_interval),
    .slot_index      (slot_index),
    .elapsed_time    (elapsed_time),
    .cmd_valid       (cmd_valid),
    .cmd_take        (cmd_take),
    .cmd             (cmd)
  );

  tbop_back #(.TIMER_SLOTS(TIMER_SLOTS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .cmd       (cmd),
    .res_ok    (!outq_full),
    .res_push  (res_push),
    .res       (res)
  );

  tbop_fifo #(.item_t(result_t)) u_resq (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res),
    .full  (outq_full),
    .pop   (pop),
    .dout  (res_out),
    .empty (empty)
  );

  assign result_kind   = res_out.kind;
  assign result_slot   = res_out.slot;
  assign fired_target  = res_out.target;
  assign fired_message = res_out.message;
  assign bank_full     = res_out.full;
  assign last_result   = res_out.last;

  `TBOP_NEVER(a_res_overflow, res_push && outq_full, "result word pushed into full queue")
  `TBOP_IMPLIES(a_take_valid, cmd_take, cmd_valid, "command taken from empty queue")
  `TBOP_IMPLIES(a_fire_not_last, res_push && (res.kind == KIND_FIRE), !res.last && !res.full, "fire word marked last or full")
  `TBOP_IMPLIES(a_done_last, res_push && (res.kind == KIND_DONE || res.kind == KIND_ADD || res.kind == KIND_REMOVE), res.last, "closing word not marked last")

endmodule

`default_nettype wire

@@ sim/timer_bank_oneshot_periodic_test.sv @@
`default_nettype none

module timer_bank_oneshot_periodic_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tbop_pkg::*;

  localparam int SLOTS = 16;

  typedef struct {
    cmd_t cmd;
    bit   settle;
  } timer_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  cmd_t drive_cmd = '0;

  logic        full;
  logic        empty;
  logic [1:0]  result_kind;
  logic [3:0]  result_slot;
  logic [15:0] fired_target;
  logic [31:0] fired_message;
  logic        bank_full;
  logic        last_result;

  // shadow of the slot table
  bit          slot_used [SLOTS];
  bit [15:0]   slot_tgt [SLOTS];
  bit [31:0]   slot_msg [SLOTS];
  bit [32:0]   slot_left [SLOTS];
  bit [31:0]   slot_reload [SLOTS];

  result_t     timer_results_due [$];
  timer_req_t  timer_requests [$];
  bit          settle_next = 1'b0;
  int unsigned requests_taken = 0;
  int unsigned fail_count = 0;
  bit          req_taken = 1'b0;
  bit          word_taken = 1'b0;
  int unsigned send_gap = 0;
  int unsigned pop_gap = 0;
  int unsigned hold_left = 0;
  bit          hold_started = 1'b0;

  timer_bank_oneshot_periodic uut (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .req_type       (drive_cmd.op),
    .target_id      (drive_cmd.target),
    .message_token  (drive_cmd.message),
    .delay_time     (drive_cmd.delay),
    .reload_interval(drive_cmd.interval),
    .slot_index     (drive_cmd.slot),
    .elapsed_time   (drive_cmd.elapsed),
    .empty          (empty),
    .pop            (pop),
    .result_kind    (result_kind),
    .result_slot    (result_slot),
    .fired_target   (fired_target),
    .fired_message  (fired_message),
    .bank_full      (bank_full),
    .last_result    (last_result)
  );

  always #5 clk = ~clk;

  function automatic void owe_word(logic [1:0] kind, int slot, logic [15:0] tgt,
                                   logic [31:0] msg, bit full_flag, bit last);
    result_t r;
    r.kind = kind;
    r.slot = 4'(slot);
    r.target = tgt;
    r.message = msg;
    r.full = full_flag;
    r.last = last;
    timer_results_due.push_back(r);
  endfunction

  function automatic void clear_slot(int s);
    slot_used[s] = 1'b0;
    slot_tgt[s] = '0;
    slot_msg[s] = '0;
    slot_left[s] = '0;
    slot_reload[s] = '0;
  endfunction

  function automatic void timer_bank_step(cmd_t c);
    int s;
    int free_slot;
    bit [32:0] dt;
    case (c.op)
      REQ_ADD: begin
        free_slot = -1;
        for (s = SLOTS - 1; s >= 0; s--)
          if (!slot_used[s]) free_slot = s;
        if (free_slot < 0) begin
          owe_word(KIND_ADD, 0, '0, '0, 1'b1, 1'b1);
        end else begin
          slot_used[free_slot] = 1'b1;
          slot_tgt[free_slot] = c.target;
          slot_msg[free_slot] = c.message;
          slot_left[free_slot] = {1'b0, c.delay};
          slot_reload[free_slot] = c.interval;
          owe_word(KIND_ADD, free_slot, '0, '0, 1'b0, 1'b1);
        end
      end
      REQ_REMOVE: begin
        clear_slot(int'(c.slot));
        owe_word(KIND_REMOVE, int'(c.slot), '0, '0, 1'b0, 1'b1);
      end
      REQ_TICK: begin
        dt = {1'b0, c.elapsed};
        for (s = 0; s < SLOTS; s++) begin
          if (slot_used[s] && slot_tgt[s] != 0) begin
            if (slot_left[s] <= dt) begin
              owe_word(KIND_FIRE, s, slot_tgt[s], slot_msg[s], 1'b0, 1'b0);
              if (slot_reload[s] != 0) slot_left[s] = {1'b0, slot_reload[s]};
              else clear_slot(s);
            end else begin
              slot_left[s] = slot_left[s] - dt;
            end
          end
        end
        owe_word(KIND_DONE, 0, '0, '0, 1'b0, 1'b1);
      end
      default: ;
    endcase
  endfunction

  function automatic int unsigned draw_idle();
    if (requests_taken >= 110 && requests_taken < 150) return 0;
    return $urandom_range(0, 9);
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t c;
    c.op = 2'($urandom);
    c.target = 16'($urandom);
    c.message = $urandom;
    c.delay = $urandom;
    c.interval = $urandom;
    c.slot = 4'($urandom);
    c.elapsed = $urandom;
    return c;
  endfunction

  function automatic void queue_req(cmd_t c);
    timer_req_t r;
    r.cmd = c;
    r.settle = settle_next;
    settle_next = 1'b0;
    timer_requests.push_back(r);
  endfunction

  function automatic void add_timer(logic [15:0] tgt, logic [31:0] msg, logic [31:0] dly,
                                    logic [31:0] ivl);
    cmd_t c;
    c = random_cmd();
    c.op = REQ_ADD;
    c.target = tgt;
    c.message = msg;
    c.delay = dly;
    c.interval = ivl;
    queue_req(c);
  endfunction

  function automatic void remove_timer(logic [3:0] slot);
    cmd_t c;
    c = random_cmd();
    c.op = REQ_REMOVE;
    c.slot = slot;
    queue_req(c);
  endfunction

  function automatic void tick_timers(logic [31:0] elapsed);
    cmd_t c;
    c = random_cmd();
    c.op = REQ_TICK;
    c.elapsed = elapsed;
    queue_req(c);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // request side
  always @(posedge clk) begin
    if (!rst && push && !full) begin
      timer_bank_step(drive_cmd);
      requests_taken++;
      req_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (!(push && !req_taken)) begin
        if (req_taken) begin
          req_taken = 1'b0;
          send_gap = draw_idle();
        end
        if (send_gap > 0) begin
          send_gap--;
          push <= 1'b0;
        end else if (timer_requests.size() != 0 &&
                     (!timer_requests[0].settle || timer_results_due.size() == 0)) begin
          drive_cmd <= timer_requests[0].cmd;
          push <= 1'b1;
          void'(timer_requests.pop_front());
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // result side
  always @(posedge clk) begin
    result_t want;
    if (!rst && pop && !empty) begin
      word_taken = 1'b1;
      if (timer_results_due.size() == 0) begin
        $display("%0t: word expected none, got kind %0h slot %0h", $time, result_kind,
                 result_slot);
        fail_count++;
      end else begin
        want = timer_results_due.pop_front();
        check_field("result_kind", 32'(want.kind), 32'(result_kind));
        check_field("result_slot", 32'(want.slot), 32'(result_slot));
        check_field("fired_target", 32'(want.target), 32'(fired_target));
        check_field("fired_message", want.message, fired_message);
        check_field("bank_full", 32'(want.full), 32'(bank_full));
        check_field("last_result", 32'(want.last), 32'(last_result));
      end
    end
  end

  always @(negedge clk) begin
    if (!rst) begin
      // long hold-off so the block backs up and stalls its input
      if (!hold_started && requests_taken >= 40) begin
        hold_started = 1'b1;
        hold_left = 300;
      end
      if (word_taken) begin
        word_taken = 1'b0;
        pop_gap = draw_idle();
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (pop_gap > 0) begin
        pop_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    cmd_t c;
    int unsigned made;
    int unsigned pick;
    logic [15:0] tgt;
    logic [31:0] dly;
    logic [31:0] ivl;
    logic [31:0] elapsed;

    tick_timers(32'h0);
    add_timer(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // zero target: occupies a slot, never fires or counts down
    add_timer(16'h0000, 32'h0, 32'h0, 32'h0);
    add_timer(16'h0001, 32'h0, 32'h0, 32'h0);
    add_timer(16'h1234, $urandom, 32'h0001_0000, 32'h0000_8000);
    tick_timers(32'h0);
    tick_timers(32'h0001_0000);
    tick_timers(32'hFFFF_FFFF);
    remove_timer(4'd15);
    remove_timer(4'd1);
    c = random_cmd();
    c.op = REQ_NONE;
    queue_req(c);
    // fill the bank, last add finds it full
    repeat (15)
      add_timer(16'($urandom_range(1, 16'hFFFF)), $urandom, $urandom,
                $urandom_range(0, 1) ? 32'h0 : $urandom);
    tick_timers(32'hFFFF_FFFF);

    settle_next = 1'b1;
    made = 0;
    while (made < 185) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        c = random_cmd();
        c.op = REQ_NONE;
        queue_req(c);
      end else begin
        made++;
        if (pick < 43) begin
          tgt = ($urandom_range(0, 9) == 0) ? 16'h0 : 16'($urandom_range(1, 16'hFFFF));
          dly = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 32'h0004_0000);
          case ($urandom_range(0, 5))
            0, 1, 2: ivl = 32'h0;
            3, 4: ivl = $urandom_range(1, 32'h0003_0000);
            default: ivl = $urandom;
          endcase
          add_timer(tgt, $urandom, dly, ivl);
        end else if (pick < 68) begin
          remove_timer(4'($urandom_range(0, 15)));
        end else begin
          elapsed = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 32'h0002_0000);
          tick_timers(elapsed);
        end
        if (made == 100) settle_next = 1'b1;
      end
    end

    repeat (8) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (timer_requests.size() != 0 || push) @(posedge clk);
    while (timer_results_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0 && timer_results_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("%0t: timeout, %0d words outstanding", $time, timer_results_due.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire

@@ timer_bank_oneshot_periodic.f @@
+incdir+rtl
rtl/tbop_pkg.sv
rtl/tbop_ram.sv
rtl/tbop_fifo.sv
rtl/tbop_front.sv
rtl/tbop_back.sv
rtl/timer_bank_oneshot_periodic.sv
sim/timer_bank_oneshot_periodic_test.sv
